### hdl/spinmet_pkg.sv
// Shared constants, codes, control types and the exp table of the spin glass update block.
package spinmet_pkg;

    localparam int SITE_W      = 8;
    localparam int MAX_SITES   = 256;
    localparam int CHUNK_W     = 32;
    localparam int CHUNKS      = MAX_SITES / CHUNK_W;
    localparam int CHUNK_IDX_W = 3;
    localparam int BOND_ADDR_W = SITE_W + CHUNK_IDX_W;
    localparam int EXP_ENTRIES = 256;
    localparam logic [63:0] EXP_STEP_Q32 = 64'd4034748383;

    localparam logic [1:0] REQ_STEP  = 2'd0;
    localparam logic [1:0] REQ_BOND  = 2'd1;
    localparam logic [1:0] REQ_FIELD = 2'd2;
    localparam logic [1:0] REQ_SPIN  = 2'd3;

    localparam logic [1:0] CFG_BETA   = 2'd0;
    localparam logic [1:0] CFG_INVSQ  = 2'd1;
    localparam logic [1:0] CFG_ACTIVE = 2'd2;

    typedef struct packed {
        logic                   capture;
        logic                   clr;
        logic [BOND_ADDR_W-1:0] clr_addr;
        logic                   latch;
        logic                   scan;
        logic [CHUNK_IDX_W-1:0] chunk;
        logic                   acc;
        logic                   e1;
        logic                   e2;
        logic                   e3;
        logic                   fin;
        logic                   wr;
        logic                   out_load;
    } cmd_t;

    typedef struct packed {
        logic [1:0] req;
        logic       in_range;
        logic       out_busy;
    } status_t;

    typedef logic [16:0] exp_tab_t [0:EXP_ENTRIES-1];

    function automatic exp_tab_t build_exp_tab();
        exp_tab_t    tab;
        logic [63:0] t;
        t = 64'h1_0000_0000;
        for (int k = 0; k < EXP_ENTRIES; k++)
        begin
            tab[k] = 17'((t + 64'd32768) >> 16);
            t = (t * EXP_STEP_Q32 + 64'h8000_0000) >> 32;
        end
        return tab;
    endfunction

    localparam exp_tab_t EXP_TAB = build_exp_tab();

    function automatic logic [5:0] popcount32(input logic [31:0] v);
        logic [2:0] nib [0:7];
        logic [5:0] c;
        for (int i = 0; i < 8; i++)
        begin
            nib[i] = 3'(v[4*i]) + 3'(v[4*i+1]) + 3'(v[4*i+2]) + 3'(v[4*i+3]);
        end
        c = '0;
        for (int i = 0; i < 8; i++)
        begin
            c = c + 6'(nib[i]);
        end
        return c;
    endfunction

endpackage

### hdl/spinmet_ram.sv
// Generic single write port, single read port RAM with registered read data.
module spinmet_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### hdl/spinmet_ctrl.sv
// Sequencer for clearing, loads and the neighbour scan and acceptance steps of an update.
module spinmet_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  spinmet_pkg::status_t status,
    output spinmet_pkg::cmd_t    cmd
);
    import spinmet_pkg::*;

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_RD   = 4'd2;
    localparam logic [3:0] S_RDW  = 4'd3;
    localparam logic [3:0] S_SCAN = 4'd4;
    localparam logic [3:0] S_LAST = 4'd5;
    localparam logic [3:0] S_E1   = 4'd6;
    localparam logic [3:0] S_E2   = 4'd7;
    localparam logic [3:0] S_E3   = 4'd8;
    localparam logic [3:0] S_E4   = 4'd9;
    localparam logic [3:0] S_WR   = 4'd10;
    localparam logic [3:0] S_OUT  = 4'd11;

    logic [3:0]             state_reg, state_next;
    logic [BOND_ADDR_W-1:0] clr_reg, clr_next;
    logic [CHUNK_IDX_W-1:0] cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            clr_reg   <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        cnt_next     = cnt_reg;
        cmd          = '0;
        cmd.clr_addr = clr_reg;
        cmd.chunk    = cnt_reg;
        unique case (state_reg)
            S_CLR:
            begin
                cmd.clr  = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (&clr_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_RD;
                end
            end
            S_RD:
            begin
                state_next = S_RDW;
            end
            S_RDW:
            begin
                cmd.latch = 1'b1;
                cnt_next  = '0;
                if (status.req == REQ_STEP)
                begin
                    state_next = status.in_range ? S_SCAN : S_OUT;
                end
                else
                begin
                    state_next = S_WR;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                cmd.acc  = (cnt_reg != '0);
                cnt_next = cnt_reg + 1'b1;
                if (&cnt_reg)
                begin
                    state_next = S_LAST;
                end
            end
            S_LAST:
            begin
                cmd.acc    = 1'b1;
                state_next = S_E1;
            end
            S_E1:
            begin
                cmd.e1     = 1'b1;
                state_next = S_E2;
            end
            S_E2:
            begin
                cmd.e2     = 1'b1;
                state_next = S_E3;
            end
            S_E3:
            begin
                cmd.e3     = 1'b1;
                state_next = S_E4;
            end
            S_E4:
            begin
                cmd.fin    = 1'b1;
                state_next = S_OUT;
            end
            S_WR:
            begin
                cmd.wr     = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!status.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLR;
            end
        endcase
    end

endmodule

### hdl/spinmet_dp.sv
// Datapath: memories, configuration, neighbour counting, energy change and acceptance.
module spinmet_dp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  spinmet_pkg::cmd_t    cmd,
    output spinmet_pkg::status_t status,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [15:0]          cfg_data,
    input  logic [1:0]           req_type,
    input  logic [7:0]           site,
    input  logic [7:0]           neighbour,
    input  logic                 bond_present,
    input  logic                 bond_positive,
    input  logic signed [15:0]   local_field,
    input  logic                 spin_bit,
    input  logic [15:0]          uniform_a,
    input  logic [15:0]          uniform_b,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [7:0]           out_site,
    output logic                 spin_a,
    output logic                 spin_b,
    output logic                 flipped_a,
    output logic                 flipped_b,
    output logic signed [10:0]   bond_sum_a
);
    import spinmet_pkg::*;

    logic [15:0] beta_reg, invsq_reg;
    logic [8:0]  active_reg;

    logic [1:0]         req_reg;
    logic [7:0]         site_reg, nb_reg;
    logic               bp_reg, bs_reg, sb_reg;
    logic signed [15:0] lf_reg;
    logic [15:0]        ua_reg, ub_reg;

    logic [CHUNK_W-1:0]     self_a_reg, self_b_reg, bex_reg, bsg_reg;
    logic signed [15:0]     h_reg;
    logic [CHUNK_IDX_W-1:0] chunk_q_reg;
    logic [8:0]             pres_reg, tra_reg, trb_reg;
    logic signed [27:0]     dra_reg, drb_reg, dea_reg, deb_reg;
    logic [42:0]            xa_reg, xb_reg;
    logic                   posa_reg, posb_reg;
    logic                   res_sa_reg, res_sb_reg, res_fa_reg, res_fb_reg;
    logic                   out_valid_reg;

    logic [8:0]             n_sites;
    logic                   si_a, si_b;
    logic [CHUNK_W-1:0]     mask, pres_bits, ta_bits, tb_bits, bit_sel;
    logic signed [11:0]     sum_a12, sum_b12;
    logic signed [10:0]     sum_a, sum_b;
    logic signed [27:0]     h32;
    logic                   fa, fb;
    logic [16:0]            pa, pb;

    logic [BOND_ADDR_W-1:0] bond_raddr, bond_waddr;
    logic [2*CHUNK_W-1:0]   bond_wdata, bond_q;
    logic                   bond_we;
    logic [CHUNK_IDX_W-1:0] spin_raddr, spin_waddr;
    logic [CHUNK_W-1:0]     spa_wdata, spb_wdata, spa_q, spb_q;
    logic                   spa_we, spb_we;
    logic [SITE_W-1:0]      fld_waddr;
    logic [15:0]            fld_wdata, fld_q;
    logic                   fld_we;

    assign n_sites  = active_reg[8] ? 9'(MAX_SITES) : active_reg;
    assign si_a     = self_a_reg[site_reg[4:0]];
    assign si_b     = self_b_reg[site_reg[4:0]];
    assign bit_sel  = CHUNK_W'(1) << site_reg[4:0];

    always_comb
    begin
        for (int k = 0; k < CHUNK_W; k++)
        begin
            mask[k] = ({1'b0, chunk_q_reg, 5'(k)} < n_sites);
        end
    end

    assign pres_bits = bond_q[CHUNK_W-1:0] & mask;
    assign ta_bits = pres_bits & (bond_q[2*CHUNK_W-1:CHUNK_W] ^ {CHUNK_W{si_a}} ^ spa_q);
    assign tb_bits = pres_bits & (bond_q[2*CHUNK_W-1:CHUNK_W] ^ {CHUNK_W{si_b}} ^ spb_q);

    assign sum_a12 = $signed({1'b0, tra_reg, 2'b00}) - $signed({2'b00, pres_reg, 1'b0});
    assign sum_b12 = $signed({1'b0, trb_reg, 2'b00}) - $signed({2'b00, pres_reg, 1'b0});
    assign sum_a   = sum_a12[10:0];
    assign sum_b   = sum_b12[10:0];
    assign h32     = {{7{h_reg[15]}}, h_reg, 5'b00000};

    assign pa = EXP_TAB[xa_reg[27:20]];
    assign pb = EXP_TAB[xb_reg[27:20]];
    assign fa = !posa_reg || (~|xa_reg[42:28] && ({1'b0, ua_reg} < pa));
    assign fb = !posb_reg || (~|xb_reg[42:28] && ({1'b0, ub_reg} < pb));

    always_comb
    begin
        bond_raddr = cmd.scan ? {site_reg, cmd.chunk} : {site_reg, nb_reg[7:5]};
        spin_raddr = cmd.scan ? cmd.chunk : site_reg[7:5];
        bond_we    = cmd.clr || (cmd.wr && req_reg == REQ_BOND);
        bond_waddr = cmd.clr ? cmd.clr_addr : {site_reg, nb_reg[7:5]};
        bond_wdata = '0;
        spin_waddr = cmd.clr ? cmd.clr_addr[CHUNK_IDX_W-1:0] : site_reg[7:5];
        spa_we     = cmd.clr || cmd.fin || (cmd.wr && req_reg == REQ_SPIN);
        spb_we     = spa_we;
        spa_wdata  = '0;
        spb_wdata  = '0;
        fld_we     = cmd.clr || (cmd.wr && req_reg == REQ_FIELD);
        fld_waddr  = cmd.clr ? cmd.clr_addr[SITE_W-1:0] : site_reg;
        fld_wdata  = cmd.clr ? 16'd0 : lf_reg;
        if (!cmd.clr)
        begin
            for (int k = 0; k < CHUNK_W; k++)
            begin
                bond_wdata[k]         = (5'(k) == nb_reg[4:0]) ? bp_reg : bex_reg[k];
                bond_wdata[CHUNK_W+k] = (5'(k) == nb_reg[4:0]) ? bs_reg : bsg_reg[k];
            end
            if (cmd.fin)
            begin
                spa_wdata = self_a_reg ^ (fa ? bit_sel : '0);
                spb_wdata = self_b_reg ^ (fb ? bit_sel : '0);
            end
            else
            begin
                spa_wdata = sb_reg ? (self_a_reg | bit_sel) : (self_a_reg & ~bit_sel);
                spb_wdata = sb_reg ? (self_b_reg | bit_sel) : (self_b_reg & ~bit_sel);
            end
        end
    end

    spinmet_ram #(.WIDTH(2*CHUNK_W), .DEPTH(MAX_SITES*CHUNKS)) u_bond_ram (
        .clk(clk), .we(bond_we), .waddr(bond_waddr), .wdata(bond_wdata),
        .raddr(bond_raddr), .rdata(bond_q)
    );

    spinmet_ram #(.WIDTH(CHUNK_W), .DEPTH(CHUNKS)) u_spin_a_ram (
        .clk(clk), .we(spa_we), .waddr(spin_waddr), .wdata(spa_wdata),
        .raddr(spin_raddr), .rdata(spa_q)
    );

    spinmet_ram #(.WIDTH(CHUNK_W), .DEPTH(CHUNKS)) u_spin_b_ram (
        .clk(clk), .we(spb_we), .waddr(spin_waddr), .wdata(spb_wdata),
        .raddr(spin_raddr), .rdata(spb_q)
    );

    spinmet_ram #(.WIDTH(16), .DEPTH(MAX_SITES)) u_field_ram (
        .clk(clk), .we(fld_we), .waddr(fld_waddr), .wdata(fld_wdata),
        .raddr(site_reg), .rdata(fld_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beta_reg      <= 16'd256;
            invsq_reg     <= 16'd4096;
            active_reg    <= 9'd256;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_BETA:   beta_reg   <= cfg_data;
                    CFG_INVSQ:  invsq_reg  <= cfg_data;
                    CFG_ACTIVE: active_reg <= cfg_data[8:0];
                    default:    ;
                endcase
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        chunk_q_reg <= cmd.chunk;
        if (cmd.capture)
        begin
            req_reg  <= req_type;
            site_reg <= site;
            nb_reg   <= neighbour;
            bp_reg   <= bond_present;
            bs_reg   <= bond_positive;
            lf_reg   <= local_field;
            sb_reg   <= spin_bit;
            ua_reg   <= uniform_a;
            ub_reg   <= uniform_b;
        end
        if (cmd.latch)
        begin
            self_a_reg <= spa_q;
            self_b_reg <= spb_q;
            bex_reg    <= bond_q[CHUNK_W-1:0];
            bsg_reg    <= bond_q[2*CHUNK_W-1:CHUNK_W];
            h_reg      <= fld_q;
            pres_reg   <= '0;
            tra_reg    <= '0;
            trb_reg    <= '0;
            res_sa_reg <= spa_q[site_reg[4:0]];
            res_sb_reg <= spb_q[site_reg[4:0]];
            res_fa_reg <= 1'b0;
            res_fb_reg <= 1'b0;
        end
        if (cmd.acc)
        begin
            pres_reg <= pres_reg + 9'(popcount32(pres_bits));
            tra_reg  <= tra_reg + 9'(popcount32(ta_bits));
            trb_reg  <= trb_reg + 9'(popcount32(tb_bits));
        end
        if (cmd.e1)
        begin
            dra_reg <= sum_a * $signed({1'b0, invsq_reg});
            drb_reg <= sum_b * $signed({1'b0, invsq_reg});
        end
        if (cmd.e2)
        begin
            dea_reg <= dra_reg;
            deb_reg <= si_b ? (drb_reg + h32) : (drb_reg - h32);
        end
        if (cmd.e3)
        begin
            posa_reg <= !dea_reg[27] && (|dea_reg);
            posb_reg <= !deb_reg[27] && (|deb_reg);
            xa_reg   <= 43'(dea_reg[26:0]) * 43'(beta_reg);
            xb_reg   <= 43'(deb_reg[26:0]) * 43'(beta_reg);
        end
        if (cmd.fin)
        begin
            res_sa_reg <= si_a ^ fa;
            res_sb_reg <= si_b ^ fb;
            res_fa_reg <= fa;
            res_fb_reg <= fb;
        end
        if (cmd.wr && req_reg == REQ_SPIN)
        begin
            res_sa_reg <= sb_reg;
            res_sb_reg <= sb_reg;
        end
        if (cmd.out_load)
        begin
            out_site   <= site_reg;
            spin_a     <= res_sa_reg;
            spin_b     <= res_sb_reg;
            flipped_a  <= res_fa_reg;
            flipped_b  <= res_fb_reg;
            bond_sum_a <= sum_a;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status.req      = req_reg;
    assign status.in_range = ({1'b0, site_reg} < n_sites);
    assign status.out_busy = out_valid_reg && !out_ready;

endmodule

### hdl/spin_glass_metropolis_update.sv
// Top level of the two replica Metropolis spin glass update block.
//
// Requests enter on the in channel (in_valid/in_ready) and each one yields
// exactly one result on the out channel (out_valid/out_ready). A request is
// a step of one site or a load of a bond, a field or an initial spin.
// The block works on one request at a time. A step reads the site's own
// spins and field, streams the coupling row and neighbour spins in eight
// 32-column words, does the multiply and table lookup, and then loads the
// result. A load writes its memory before the result is loaded, and an
// out-of-range step loads its result straight after the read.
// The output register holds a result until it is taken, and the next
// request is accepted meanwhile; a finished request waits in the sequencer
// while the receiver stalls.
// After reset a clearing pass zeroes the coupling, spin and field
// memories, during which in_ready is low. Configuration writes go
// through cfg_we, cfg_index and cfg_data; the user must make them only
// while no request is in flight, as the block does not enforce this.
module spin_glass_metropolis_update (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         req_type,
    input  logic [7:0]         site,
    input  logic [7:0]         neighbour,
    input  logic               bond_present,
    input  logic               bond_positive,
    input  logic signed [15:0] local_field,
    input  logic               spin_bit,
    input  logic [15:0]        uniform_a,
    input  logic [15:0]        uniform_b,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         out_site,
    output logic               spin_a,
    output logic               spin_b,
    output logic               flipped_a,
    output logic               flipped_b,
    output logic signed [10:0] bond_sum_a
);
    import spinmet_pkg::*;

    cmd_t    cmd;
    status_t status;

    spinmet_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .status(status), .cmd(cmd)
    );

    spinmet_dp u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .status(status),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .req_type(req_type), .site(site), .neighbour(neighbour),
        .bond_present(bond_present), .bond_positive(bond_positive),
        .local_field(local_field), .spin_bit(spin_bit),
        .uniform_a(uniform_a), .uniform_b(uniform_b),
        .out_valid(out_valid), .out_ready(out_ready), .out_site(out_site),
        .spin_a(spin_a), .spin_b(spin_b), .flipped_a(flipped_a),
        .flipped_b(flipped_b), .bond_sum_a(bond_sum_a)
    );

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request accepted while another is in progress");

    a_even_sum: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !bond_sum_a[0])
        else $error("odd coupling sum");

    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared without a request in progress");

endmodule
